// ===== design/nftd_pkg.sv =====
`default_nettype none
package nftd_pkg;

	localparam int RADIUS_DEF    = 2;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam int PIX_W  = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 13;
	localparam int ROW_W  = 14;
	localparam int POS_W  = 28;

	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_THRESHOLD    = 2'd2;

	localparam logic OP_PIXEL = 1'b0;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
	localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QCALC,
		ST_CHECK,
		ST_PREP,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic calc_q;
		logic owrap;
		logic prep;
		logic scan_next;
		logic res_load;
		logic res_changed;
		logic adv_out;
	} dp_cmd_t;

	typedef struct packed {
		logic q_lt_lag;
		logic interior;
		logic match;
		logic scan_end;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/nftd_ram.sv =====
`default_nettype none
module nftd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/nftd_ctrl.sv =====
`default_nettype none
module nftd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      nftd_pkg::dp_cmd_t    cmd,
	input  wire nftd_pkg::dp_status_t sts
);
	import nftd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_QCALC;
				end
			end
			ST_QCALC: begin
				cmd.calc_q = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.q_lt_lag) begin
					state_d = ST_IDLE;
				end else begin
					cmd.owrap = 1'b1;
					state_d   = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.interior) begin
					state_d = ST_SCAN;
				end else begin
					cmd.res_load    = 1'b1;
					cmd.res_changed = 1'b0;
					state_d         = ST_OUT;
				end
			end
			ST_SCAN: begin
				priority if (sts.match) begin
					cmd.res_load    = 1'b1;
					cmd.res_changed = 1'b0;
					state_d         = ST_OUT;
				end else if (sts.scan_end) begin
					cmd.res_load    = 1'b1;
					cmd.res_changed = 1'b1;
					state_d         = ST_OUT;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.adv_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/nftd_dp.sv =====
`default_nettype none
module nftd_dp #(
	parameter int RADIUS    = nftd_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH = nftd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nftd_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [nftd_pkg::CFG_DW-1:0]    cfg_data,
	input  wire logic                           opcode,
	input  wire logic [nftd_pkg::PIX_W-1:0]     current_pixel,
	input  wire logic [nftd_pkg::PIX_W-1:0]     reference_pixel,
	input  wire nftd_pkg::dp_cmd_t              cmd,
	output      nftd_pkg::dp_status_t           sts,
	output      logic                           changed,
	output      logic                           frame_end
);
	import nftd_pkg::*;

	localparam int STORE_ROWS = 2 * RADIUS + 2;
	localparam int SRW        = $clog2(STORE_ROWS);
	localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = $clog2(MAX_WIDTH + 1);
	localparam int XW         = CW + 2;
	localparam int YW         = ROW_W + 1;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [PIX_W-1:0] thr_q;

	logic [CW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;

	logic [ROW_W-1:0] in_row_q, out_row_q, q_row_q;
	logic [CW-1:0]    in_col_q, out_col_q, q_col_q;
	logic [SRW-1:0]   in_srow_q, out_srow_q;
	logic [POS_W-1:0] q_s, lag_s;

	logic [ROW_W-1:0] y_q, r1_q;
	logic [CW-1:0]    x_q, c0_q, c1_q;
	logic [SRW-1:0]   ysr_q;
	logic             last_q;

	logic [ROW_W-1:0] r0_c, r1_c;
	logic [CW-1:0]    c0_c, c1_c;
	logic [SRW-1:0]   ysr0_c, dr_c;
	logic             interior_c, last_c;

	logic [ROW_W-1:0] y_n;
	logic [CW-1:0]    x_n;
	logic [SRW-1:0]   ysr_n;

	logic             wr_en, ref_re;
	logic [AW-1:0]    wr_addr, cur_addr, ref_addr;
	logic [PIX_W-1:0] cur_data, ref_data, diff;

	function automatic logic [AW-1:0] store_addr(input logic [SRW-1:0] sr,
			input logic [CW-1:0] col);
		return AW'(AW'(sr) * AW'(MAX_WIDTH) + AW'(col));
	endfunction

	function automatic logic [SRW-1:0] srow_inc(input logic [SRW-1:0] sr);
		return (sr == SRW'(STORE_ROWS - 1)) ? '0 : SRW'(sr + 1'b1);
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FRAME_WIDTH_RST;
			fh_q  <= FRAME_HEIGHT_RST;
			thr_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: fh_q  <= cfg_data[FH_W-1:0];
				CFG_THRESHOLD:    thr_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (fw_q == '0) begin
			eff_w = CW'(1);
		end else if (XW'(fw_q) > XW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(fw_q);
		end
		eff_h = (fh_q == '0) ? FH_W'(1) : fh_q;
	end

	// window bounds for the output position
	always_comb begin
		interior_c = (out_row_q != '0) && (YW'(out_row_q) + YW'(2) <= YW'(eff_h)) &&
			(out_col_q != '0) && (XW'(out_col_q) + XW'(2) <= XW'(eff_w));
		last_c = (YW'(out_row_q) + YW'(1) >= YW'(eff_h)) &&
			(XW'(out_col_q) + XW'(1) >= XW'(eff_w));
		r0_c = (out_row_q >= ROW_W'(RADIUS)) ? ROW_W'(out_row_q - ROW_W'(RADIUS)) : '0;
		r1_c = (YW'(out_row_q) + YW'(RADIUS) > YW'(eff_h) - YW'(1)) ?
			ROW_W'(YW'(eff_h) - YW'(1)) : ROW_W'(YW'(out_row_q) + YW'(RADIUS));
		c0_c = (out_col_q >= CW'(RADIUS)) ? CW'(out_col_q - CW'(RADIUS)) : '0;
		c1_c = (XW'(out_col_q) + XW'(RADIUS) > XW'(eff_w) - XW'(1)) ?
			CW'(XW'(eff_w) - XW'(1)) : CW'(XW'(out_col_q) + XW'(RADIUS));
		dr_c = SRW'(out_row_q - r0_c);
		ysr0_c = (out_srow_q >= dr_c) ? SRW'(out_srow_q - dr_c) :
			SRW'(out_srow_q + SRW'(STORE_ROWS) - dr_c);
	end

	always_comb begin
		if (x_q == c1_q) begin
			x_n   = c0_q;
			y_n   = ROW_W'(y_q + 1'b1);
			ysr_n = srow_inc(ysr_q);
		end else begin
			x_n   = CW'(x_q + 1'b1);
			y_n   = y_q;
			ysr_n = ysr_q;
		end
	end

	assign diff = (ref_data > cur_data) ? PIX_W'(ref_data - cur_data) :
		PIX_W'(cur_data - ref_data);

	assign sts.q_lt_lag = q_s < lag_s;
	assign sts.interior = interior_c;
	assign sts.match    = diff <= thr_q;
	assign sts.scan_end = (y_q == r1_q) && (x_q == c1_q);

	// stores
	assign wr_en = cmd.accept && (opcode == OP_PIXEL) &&
		(YW'(in_row_q) < YW'(eff_h)) && (in_col_q < eff_w);
	assign wr_addr  = store_addr(in_srow_q, in_col_q);
	assign cur_addr = store_addr(out_srow_q, out_col_q);
	assign ref_re   = cmd.prep || cmd.scan_next;
	assign ref_addr = cmd.prep ? store_addr(ysr0_c, c0_c) : store_addr(ysr_n, x_n);

	nftd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_cur_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (current_pixel),
		.re    (cmd.prep),
		.raddr (cur_addr),
		.rdata (cur_data)
	);

	nftd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ref_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (reference_pixel),
		.re    (ref_re),
		.raddr (ref_addr),
		.rdata (ref_data)
	);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_srow_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_srow_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (XW'(in_col_q) + XW'(1) >= XW'(eff_w)) begin
					in_col_q  <= '0;
					in_row_q  <= ROW_W'(in_row_q + 1'b1);
					in_srow_q <= srow_inc(in_srow_q);
				end else begin
					in_col_q <= CW'(in_col_q + 1'b1);
				end
			end
			if (cmd.owrap && (out_col_q >= eff_w)) begin
				out_col_q  <= '0;
				out_row_q  <= ROW_W'(out_row_q + 1'b1);
				out_srow_q <= srow_inc(out_srow_q);
			end
			if (cmd.adv_out) begin
				if (last_q) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					in_srow_q  <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_srow_q <= '0;
				end else if (XW'(out_col_q) + XW'(1) >= XW'(eff_w)) begin
					out_col_q  <= '0;
					out_row_q  <= ROW_W'(out_row_q + 1'b1);
					out_srow_q <= srow_inc(out_srow_q);
				end else begin
					out_col_q <= CW'(out_col_q + 1'b1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			q_row_q <= in_row_q;
			q_col_q <= in_col_q;
		end
		if (cmd.calc_q) begin
			q_s   <= POS_W'(POS_W'(q_row_q) * POS_W'(eff_w) + POS_W'(q_col_q));
			lag_s <= POS_W'(POS_W'(RADIUS) * POS_W'(eff_w) + POS_W'(RADIUS));
		end
		if (cmd.prep) begin
			y_q    <= r0_c;
			r1_q   <= r1_c;
			x_q    <= c0_c;
			c0_q   <= c0_c;
			c1_q   <= c1_c;
			ysr_q  <= ysr0_c;
			last_q <= last_c;
		end
		if (cmd.scan_next) begin
			y_q   <= y_n;
			x_q   <= x_n;
			ysr_q <= ysr_n;
		end
		if (cmd.res_load) begin
			changed   <= cmd.res_changed;
			frame_end <= cmd.prep ? last_c : last_q;
		end
	end
endmodule
`default_nettype wire

// ===== design/neighborhood_tolerant_frame_diff_unit.sv =====
`default_nettype none
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    opcode, current_pixel, reference_pixel
// out      output     out_valid / out_ready  changed, frame_end
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time. An item with no result passes through accept, position
// multiply and lag compare. An item with a border result then also passes through
// window prep and output; an interior one also scans reference pixels between
// prep and output, up to (2*RADIUS+1)^2; both also wait out any output stall. The
// window scan goes through the single read port of the reference line RAM.
// Reset clears counters, config and control; the line RAMs are not cleared.
// cfg_ready is always high.
module neighborhood_tolerant_frame_diff_unit #(
	parameter int RADIUS    = nftd_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH = nftd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [nftd_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [nftd_pkg::CFG_DW-1:0] cfg_data,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        opcode,
	input  wire logic [nftd_pkg::PIX_W-1:0]  current_pixel,
	input  wire logic [nftd_pkg::PIX_W-1:0]  reference_pixel,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic                        changed,
	output      logic                        frame_end
);
	import nftd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	nftd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	nftd_dp #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.current_pixel   (current_pixel),
		.reference_pixel (reference_pixel),
		.cmd             (cmd),
		.sts             (sts),
		.changed         (changed),
		.frame_end       (frame_end)
	);
endmodule
`default_nettype wire

// ===== tb/sv/neighborhood_tolerant_frame_diff_unit_test.sv =====
`default_nettype none
module neighborhood_tolerant_frame_diff_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nftd_pkg::*;

	localparam int RAD       = RADIUS_DEF;
	localparam int MAXW      = MAX_WIDTH_DEF;
	localparam int LINES     = 2 * RAD + 2;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct {
		logic chg;
		logic last;
	} mask_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index;
	logic [CFG_DW-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 opcode;
	logic [PIX_W-1:0]     current_pixel;
	logic [PIX_W-1:0]     reference_pixel;
	logic                 out_valid;
	logic                 out_ready;
	logic                 changed;
	logic                 frame_end;

	neighborhood_tolerant_frame_diff_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .current_pixel(current_pixel),
		.reference_pixel(reference_pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.changed(changed), .frame_end(frame_end)
	);

	// predictor state
	logic [PIX_W-1:0] cur_lines [LINES][MAXW];
	logic [PIX_W-1:0] ref_lines [LINES][MAXW];
	int               in_row, in_col, out_row, out_col;
	int               cfg_w, cfg_h, cfg_thr;
	mask_word_t       mask_q[$];

	int  items_sent;
	int  mismatches;
	int  matched;
	bit  fail_flag;
	bit  quiet;
	int  hold_cycles;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	function automatic int eff_w();
		if (cfg_w == 0) return 1;
		if (cfg_w > MAXW) return MAXW;
		return cfg_w;
	endfunction

	function automatic int eff_h();
		return (cfg_h == 0) ? 1 : cfg_h;
	endfunction

	function automatic logic window_empty(int r, int c, int w, int h);
		int r0, r1, c0, c1, d;
		int cur;
		if (r < 1 || r > h - 2 || c < 1 || c > w - 2) return 1'b0;
		cur = cur_lines[r % LINES][c];
		r0 = (r - RAD < 0) ? 0 : r - RAD;
		r1 = (r + RAD > h - 1) ? h - 1 : r + RAD;
		c0 = (c - RAD < 0) ? 0 : c - RAD;
		c1 = (c + RAD > w - 1) ? w - 1 : c + RAD;
		for (int y = r0; y <= r1; y++)
			for (int x = c0; x <= c1; x++) begin
				d = int'(ref_lines[y % LINES][x]) - cur;
				if (d < 0) d = -d;
				if (d <= cfg_thr) return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic void predict_mask(logic op, logic [7:0] cp, logic [7:0] rp);
		int w, h, lag, pos;
		mask_word_t m;
		w = eff_w();
		h = eff_h();
		lag = RAD * w + RAD;
		pos = in_row * w + in_col;
		if (op == OP_PIXEL && in_row < h && in_col < w) begin
			cur_lines[in_row % LINES][in_col] = cp;
			ref_lines[in_row % LINES][in_col] = rp;
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (pos < lag) return;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		m.chg = window_empty(out_row, out_col, w, h);
		m.last = (out_row >= h - 1 && out_col >= w - 1);
		mask_q.push_back(m);
		if (m.last) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		mask_word_t m;
		if (arst_n && out_valid && out_ready) begin
			if (mask_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: changed=%0b frame_end=%0b", changed, frame_end);
			end else begin
				m = mask_q.pop_front();
				if (changed !== m.chg || frame_end !== m.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d: exp changed=%0b frame_end=%0b, got %0b %0b",
							matched, m.chg, m.last, changed, frame_end);
				end
				matched++;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
	end

	task automatic send_item(logic op, logic [7:0] cp, logic [7:0] rp);
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		current_pixel <= cp;
		reference_pixel <= rp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_mask(op, cp, rp);
		items_sent++;
	endtask

	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (mask_q.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DW'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH:  cfg_w = value & 'h7FF;
			CFG_FRAME_HEIGHT: cfg_h = value & 'h1FFF;
			CFG_THRESHOLD:    cfg_thr = value & 'hFF;
			default: ;
		endcase
	endtask

	task automatic setup(int w, int h, int thr);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_THRESHOLD, thr);
	endtask

	// one full frame; mode 0 random, 1 smooth, 2 alternating extremes
	task automatic send_frame(int mode);
		int w, h, n, base;
		logic [7:0] cp, rp;
		w = eff_w();
		h = eff_h();
		base = $urandom_range(255);
		for (int i = 0; i < w * h; i++) begin
			case (mode)
				1: begin
					cp = 8'(base + $urandom_range(12));
					rp = 8'(base + $urandom_range(12));
				end
				2: begin
					cp = (i % 2) ? 8'hFF : 8'h00;
					rp = (i % 3) ? 8'h00 : 8'hFF;
				end
				default: begin
					cp = 8'($urandom);
					rp = 8'($urandom);
				end
			endcase
			send_item(OP_PIXEL, cp, rp);
		end
		// trailing words: flush or ignored pixel words
		n = RAD * w + RAD;
		for (int i = 0; i < n; i++)
			send_item($urandom_range(1) ? OP_FLUSH : OP_PIXEL, 8'($urandom), 8'($urandom));
	endtask

	task automatic test_smallest_frames();
		setup(3, 3, 0);
		send_frame(2);
		setup(3, 3, 255);
		send_frame(2);
		setup(0, 0, 7);
		send_frame(0);
	endtask

	task automatic test_widest_frame();
		setup(100, 4, 6);
		send_frame(1);
	endtask

	task automatic test_output_stall();
		quiet = 1'b1;
		setup(9, 7, 3);
		hold_cycles <= 600;
		send_frame(0);
		drain();
		quiet = 1'b0;
	endtask

	task automatic test_random_frames();
		while (items_sent < 1600) begin
			setup($urandom_range(12, 3), $urandom_range(10, 3),
				$urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(16));
			send_frame($urandom_range(2) == 0 ? 0 : 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_PIXEL;
		current_pixel = '0;
		reference_pixel = '0;
		hold_cycles = 0;
		quiet = 1'b0;
		items_sent = 0;
		mismatches = 0;
		matched = 0;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		cfg_w = FRAME_WIDTH_RST;
		cfg_h = FRAME_HEIGHT_RST;
		cfg_thr = THRESHOLD_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_smallest_frames();
		test_output_stall();
		test_widest_frame();
		test_random_frames();
		drain();

		fail_flag = (mismatches != 0) || (mask_q.size() != 0);
		if (!fail_flag)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
